>>> src/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// shared types, constants and helpers of the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int BACK_LIMIT_DEF  = 256;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int MAX_PAT_BYTES = 32;
    localparam int PAT_REGS      = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int MASK_W        = 32;
    localparam int LENGTH_W      = 6;
    localparam int OUT_OFFSET_W  = 32;

    localparam logic [7:0] OP_PUSH_RBP = 8'h55;
    localparam logic [7:0] OP_REX_W    = 8'h48;
    localparam logic [7:0] OP_MOV      = 8'h8B;
    localparam logic [7:0] OP_SUB      = 8'h83;
    localparam logic [7:0] MODRM_RSP   = 8'hEC;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_0 = 3'd0,
        CFG_PATTERN_1 = 3'd1,
        CFG_PATTERN_2 = 3'd2,
        CFG_PATTERN_3 = 3'd3,
        CFG_WILDCARD  = 3'd4,
        CFG_LENGTH    = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_PUSH = 2'd1,
        KIND_MOV  = 2'd2,
        KIND_SUB  = 2'd3
    } kind_t;

    typedef struct packed {
        logic                    found;
        logic [OUT_OFFSET_W-1:0] hit_offset;
        logic [OUT_OFFSET_W-1:0] start_offset;
        kind_t                   start_kind;
    } result_t;

    function automatic int pat_cap(int max_pattern);
        return (max_pattern < MAX_PAT_BYTES) ? max_pattern : MAX_PAT_BYTES;
    endfunction

    function automatic int win_depth(int max_pattern);
        int c;
        c = pat_cap(max_pattern);
        return (c < 3) ? 3 : c;
    endfunction

    // prologue form that begins at byte b0, followed by b1 and b2
    function automatic kind_t prologue_kind(logic [7:0] b0, logic [7:0] b1,
                                            logic [7:0] b2, logic has_tail);
        kind_t k;
        k = KIND_NONE;
        if (b0 == OP_PUSH_RBP)
            k = KIND_PUSH;
        else if (has_tail && b0 == OP_REX_W && b2 == MODRM_RSP)
        begin
            if (b1 == OP_MOV)
                k = KIND_MOV;
            else if (b1 == OP_SUB)
                k = KIND_SUB;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

>>> src/wbps_cfg.sv
// ----------------------------------------------------------------------------
// wbps_cfg
// configuration registers and the pattern aligned to window distance
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cfg
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int WD          = win_depth(MAX_PATTERN),
    parameter int AGE_W       = $clog2(WD)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [WD-1:0]               care,
    output logic [WD-1:0][7:0]          apat,
    output logic [AGE_W-1:0]            len_m1
);

    localparam int PAT_CAP = pat_cap(MAX_PATTERN);

    logic [PAT_REGS-1:0][CFG_DATA_W-1:0] pat_reg, pat_next;
    logic [MASK_W-1:0]                   mask_reg, mask_next;
    logic [LENGTH_W-1:0]                 length_reg, length_next;

    logic [WD-1:0]                       care_reg, care_next;
    logic [WD-1:0][7:0]                  apat_reg, apat_next;
    logic [AGE_W-1:0]                    len_m1_reg, len_m1_next;

    logic [WD-1:0][7:0]                  pbytes;
    logic [WD-1:0]                       wmask;
    logic [LENGTH_W-1:0]                 n_eff;
    logic [AGE_W-1:0]                    j;

    always_comb
    begin
        pat_next    = pat_reg;
        mask_next   = mask_reg;
        length_next = length_reg;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PATTERN_0: pat_next[0] = cfg_data;
                CFG_PATTERN_1: pat_next[1] = cfg_data;
                CFG_PATTERN_2: pat_next[2] = cfg_data;
                CFG_PATTERN_3: pat_next[3] = cfg_data;
                CFG_WILDCARD:  mask_next   = cfg_data[MASK_W-1:0];
                CFG_LENGTH:    length_next = cfg_data[LENGTH_W-1:0];
                default:       ;
            endcase
        end
    end

    // aligned form is built from the next values so a write counts at once
    always_comb
    begin
        for (int i = 0; i < WD; i++)
        begin
            if (i < PAT_CAP)
            begin
                pbytes[i] = pat_next[2'(i >> 3)][8*(i & 7) +: 8];
                wmask[i]  = mask_next[5'(i)];
            end
            else
            begin
                pbytes[i] = '0;
                wmask[i]  = 1'b0;
            end
        end

        n_eff = length_next;
        if (n_eff == '0)
            n_eff = LENGTH_W'(1);
        else if (n_eff > LENGTH_W'(PAT_CAP))
            n_eff = LENGTH_W'(PAT_CAP);
        len_m1_next = AGE_W'(n_eff - LENGTH_W'(1));

        j = '0;
        for (int d = 0; d < WD; d++)
        begin
            j = len_m1_next - AGE_W'(d);
            if (AGE_W'(d) <= len_m1_next)
            begin
                care_next[d] = !wmask[j];
                apat_next[d] = pbytes[j];
            end
            else
            begin
                care_next[d] = 1'b0;
                apat_next[d] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg     <= '0;
            mask_reg    <= '0;
            length_reg  <= LENGTH_W'(1);
            care_reg    <= WD'(1);
            apat_reg    <= '0;
            len_m1_reg  <= '0;
        end
        else
        begin
            pat_reg     <= pat_next;
            mask_reg    <= mask_next;
            length_reg  <= length_next;
            care_reg    <= care_next;
            apat_reg    <= apat_next;
            len_m1_reg  <= len_m1_next;
        end
    end

    assign care   = care_reg;
    assign apat   = apat_reg;
    assign len_m1 = len_m1_reg;

endmodule

`default_nettype wire

>>> src/wbps_scan.sv
// ----------------------------------------------------------------------------
// wbps_scan
// byte window, pattern compare, prologue tracking and backtrack select
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_scan
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int BACK_LIMIT  = BACK_LIMIT_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int WD          = win_depth(MAX_PATTERN),
    parameter int AGE_W       = $clog2(WD)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              region_end,
    input  wire logic [WD-1:0]     care,
    input  wire logic [WD-1:0][7:0] apat,
    input  wire logic [AGE_W-1:0]  len_m1,
    output logic                   emit,
    output result_t                res
);

    localparam int DIST_CAP = BACK_LIMIT + WD;
    localparam int DW       = $clog2(DIST_CAP + 1);
    localparam int SEL_W    = $clog2(WD);

    logic [WD-2:0][7:0]       win_reg, win_next;
    logic [WD-2:0]            wv_reg, wv_next;
    logic [OFFSET_BITS-1:0]   count_reg, count_next;
    logic                     hit_done_reg, hit_done_next;
    logic                     pend_reg, pend_next;
    logic [AGE_W-1:0]         pend_age_reg, pend_age_next;
    logic [OFFSET_BITS-1:0]   pend_off_reg, pend_off_next;
    logic                     old_valid_reg, old_valid_next;
    logic [DW-1:0]            old_dist_reg, old_dist_next;
    kind_t                    old_kind_reg, old_kind_next;

    logic [WD-1:0][7:0]       cur;
    logic [WD-1:0]            cv;
    logic [WD+1:0][7:0]       curx;
    kind_t [WD-1:0]           fl;
    logic [WD-1:0]            cand;
    logic                     match;
    logic                     new_hit;
    logic                     pend_c;
    logic [AGE_W-1:0]         age_c;
    logic [OFFSET_BITS-1:0]   off_c;
    logic                     report;
    logic                     win_hit;
    logic [SEL_W-1:0]         sel;
    logic [DW-1:0]            kd;
    logic [DW-1:0]            k_sel;
    logic [DW-1:0]            old_k;
    kind_t                    kind_sel;
    logic [OFFSET_BITS-1:0]   start_off;

    always_comb
    begin
        cur[0] = data_byte;
        cv[0]  = 1'b1;
        for (int d = 1; d < WD; d++)
        begin
            cur[d] = win_reg[d-1];
            cv[d]  = wv_reg[d-1];
        end
        curx[0] = '0;
        curx[1] = '0;
        for (int d = 0; d < WD; d++)
            curx[d+2] = cur[d];

        match = 1'b1;
        for (int d = 0; d < WD; d++)
        begin
            if (cv[d])
                fl[d] = prologue_kind(curx[d+2], curx[d+1], curx[d], d >= 2);
            else
                fl[d] = KIND_NONE;
            match = match & (!care[d] | (cv[d] & (apat[d] == cur[d])));
        end
        // the whole pattern span has to lie inside the region
        match = match & cv[len_m1];

        new_hit = !hit_done_reg && !pend_reg && match;
        pend_c  = pend_reg || new_hit;
        age_c   = pend_reg ? (pend_age_reg + AGE_W'(1)) : len_m1;
        off_c   = pend_reg ? pend_off_reg : (count_reg - OFFSET_BITS'(len_m1));
        report  = pend_c && ((age_c >= AGE_W'(2)) || region_end);

        // nearest prologue at or before the hit inside the window
        kd = '0;
        for (int d = 0; d < WD; d++)
        begin
            kd      = DW'(d) - DW'(age_c);
            cand[d] = (fl[d] != KIND_NONE) && (AGE_W'(d) >= age_c)
                      && (kd < DW'(BACK_LIMIT));
        end
        win_hit = |cand;
        sel     = '0;
        for (int d = WD - 1; d >= 0; d--)
        begin
            if (cand[d])
                sel = SEL_W'(d);
        end

        old_k    = old_dist_reg - DW'(age_c);
        k_sel    = '0;
        kind_sel = KIND_NONE;
        if (win_hit)
        begin
            k_sel    = DW'(sel) - DW'(age_c);
            kind_sel = fl[sel];
        end
        else if (old_valid_reg && (old_k < DW'(BACK_LIMIT)))
        begin
            k_sel    = old_k;
            kind_sel = old_kind_reg;
        end
        start_off = off_c - OFFSET_BITS'(k_sel);

        emit = step && (report || (region_end && !hit_done_reg));
        if (report)
        begin
            res.found        = 1'b1;
            res.hit_offset   = OUT_OFFSET_W'(off_c);
            res.start_offset = OUT_OFFSET_W'(start_off);
            res.start_kind   = kind_sel;
        end
        else
        begin
            res.found        = 1'b0;
            res.hit_offset   = '0;
            res.start_offset = '0;
            res.start_kind   = KIND_NONE;
        end
    end

    always_comb
    begin
        win_next       = win_reg;
        wv_next        = wv_reg;
        count_next     = count_reg;
        hit_done_next  = hit_done_reg;
        pend_next      = pend_reg;
        pend_age_next  = pend_age_reg;
        pend_off_next  = pend_off_reg;
        old_valid_next = old_valid_reg;
        old_dist_next  = old_dist_reg;
        old_kind_next  = old_kind_reg;
        if (step)
        begin
            win_next[0] = data_byte;
            for (int i = 1; i < WD - 1; i++)
                win_next[i] = win_reg[i-1];
            if (region_end)
            begin
                wv_next        = '0;
                count_next     = '0;
                hit_done_next  = 1'b0;
                pend_next      = 1'b0;
                old_valid_next = 1'b0;
            end
            else
            begin
                wv_next[0] = 1'b1;
                for (int i = 1; i < WD - 1; i++)
                    wv_next[i] = wv_reg[i-1];
                count_next    = count_reg + OFFSET_BITS'(1);
                hit_done_next = hit_done_reg || report;
                pend_next     = pend_c && !report;
                pend_age_next = age_c;
                pend_off_next = off_c;
                // oldest window position leaves into the tracker
                if (fl[WD-1] != KIND_NONE)
                begin
                    old_valid_next = 1'b1;
                    old_dist_next  = DW'(WD);
                    old_kind_next  = fl[WD-1];
                end
                else if (old_valid_reg && (old_dist_reg != DW'(DIST_CAP)))
                begin
                    old_dist_next = old_dist_reg + DW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg        <= '0;
            count_reg     <= '0;
            hit_done_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            old_valid_reg <= 1'b0;
        end
        else
        begin
            wv_reg        <= wv_next;
            count_reg     <= count_next;
            hit_done_reg  <= hit_done_next;
            pend_reg      <= pend_next;
            old_valid_reg <= old_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        pend_age_reg <= pend_age_next;
        pend_off_reg <= pend_off_next;
        old_dist_reg <= old_dist_next;
        old_kind_reg <= old_kind_next;
    end

endmodule

`default_nettype wire

>>> src/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// finds the first wildcard pattern hit in a byte region and backtracks to
// the nearest function prologue
// ----------------------------------------------------------------------------
// One byte beat is taken every clock cycle while in_stall is low; each beat
// goes into the input register and the result it yields into the result
// register. The pattern
// compare and the prologue priority encoder over the byte window sit in the
// single stage between those registers. Prologues older than the window are
// kept as one tracked position with its distance, so no flag memory is swept.
// A stalled result holds back the byte in the input register and new beats.
`default_nettype none

module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int BACK_LIMIT  = BACK_LIMIT_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [7:0]              data_byte,
    input  wire logic                    region_end,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         found,
    output logic [OUT_OFFSET_W-1:0]      hit_offset,
    output logic [OUT_OFFSET_W-1:0]      start_offset,
    output logic [1:0]                   start_kind
);

    localparam int WD    = win_depth(MAX_PATTERN);
    localparam int AGE_W = $clog2(WD);

    logic                in_full_reg, in_full_next;
    logic [7:0]          in_byte_reg, in_byte_next;
    logic                in_end_reg, in_end_next;
    logic                out_full_reg, out_full_next;
    result_t             out_res_reg, out_res_next;

    logic                proc;
    logic                accept;
    logic                emit;
    result_t             res;
    logic [WD-1:0]       care;
    logic [WD-1:0][7:0]  apat;
    logic [AGE_W-1:0]    len_m1;

    wbps_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .WD          (WD),
        .AGE_W       (AGE_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .care      (care),
        .apat      (apat),
        .len_m1    (len_m1)
    );

    wbps_scan #(
        .MAX_PATTERN (MAX_PATTERN),
        .BACK_LIMIT  (BACK_LIMIT),
        .OFFSET_BITS (OFFSET_BITS),
        .WD          (WD),
        .AGE_W       (AGE_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (proc),
        .data_byte  (in_byte_reg),
        .region_end (in_end_reg),
        .care       (care),
        .apat       (apat),
        .len_m1     (len_m1),
        .emit       (emit),
        .res        (res)
    );

    assign proc     = in_full_reg && !(out_full_reg && out_stall);
    assign in_stall = in_full_reg && !proc;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_full_next  = in_full_reg;
        in_byte_next  = in_byte_reg;
        in_end_next   = in_end_reg;
        out_full_next = out_full_reg;
        out_res_next  = out_res_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
            in_byte_next = data_byte;
            in_end_next  = region_end;
        end
        else if (proc)
        begin
            in_full_next = 1'b0;
        end
        if (proc && emit)
        begin
            out_full_next = 1'b1;
            out_res_next  = res;
        end
        else if (out_full_reg && !out_stall)
        begin
            out_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        in_end_reg  <= in_end_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid    = out_full_reg;
    assign found        = out_res_reg.found;
    assign hit_offset   = out_res_reg.hit_offset;
    assign start_offset = out_res_reg.start_offset;
    assign start_kind   = out_res_reg.start_kind;

endmodule

`default_nettype wire
